/* design/gzip_header_parser_unit_assert.svh */
// ----------------------------------------------------------------------------
// gzip header parser assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GZIP_HEADER_PARSER_UNIT_ASSERT_SVH
`define GZIP_HEADER_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define GZHP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gzhp check failed");
`define GZHP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gzhp check failed");
`else
`define GZHP_ASSERT_IMP(label, ante, cons)
`define GZHP_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* design/gzhp_pkg.sv */
// ----------------------------------------------------------------------------
// gzhp_pkg
// Phase codes, flag masks, item kinds and the optional-part sequencer.
// ----------------------------------------------------------------------------
package gzhp_pkg;

  typedef logic [2:0] phase_t;
  typedef logic [2:0] kind_t;
  typedef logic [4:0] flags_t;

  localparam phase_t PH_FIXED    = 3'd0;
  localparam phase_t PH_EXTRA_LO = 3'd1;
  localparam phase_t PH_EXTRA_HI = 3'd2;
  localparam phase_t PH_EXTRA    = 3'd3;
  localparam phase_t PH_NAME     = 3'd4;
  localparam phase_t PH_COMMENT  = 3'd5;
  localparam phase_t PH_HCRC     = 3'd6;
  localparam phase_t PH_PAYLOAD  = 3'd7;

  localparam kind_t KIND_HEADER  = 3'd0;
  localparam kind_t KIND_NAME    = 3'd1;
  localparam kind_t KIND_COMMENT = 3'd2;
  localparam kind_t KIND_PAYLOAD = 3'd3;
  localparam kind_t KIND_REJECT  = 3'd4;

  localparam logic [7:0] FL_RESERVED    = 8'hE0;
  localparam logic [7:0] FL_EXTRA       = 8'h04;
  localparam logic [7:0] FL_NAME        = 8'h08;
  localparam logic [7:0] FL_COMMENT     = 8'h10;
  localparam logic [7:0] FL_HCRC        = 8'h02;
  localparam logic [7:0] METHOD_DEFLATE = 8'h08;

  localparam logic [3:0] FIX_METHOD = 4'd2;
  localparam logic [3:0] FIX_FLAGS  = 4'd3;
  localparam logic [3:0] FIX_LAST   = 4'd9;

  localparam logic [1:0] STG_EXTRA   = 2'd0;
  localparam logic [1:0] STG_NAME    = 2'd1;
  localparam logic [1:0] STG_COMMENT = 2'd2;
  localparam logic [1:0] STG_HCRC    = 2'd3;

  // first optional part at or after the given stage, else the payload
  function automatic phase_t next_phase(input flags_t flags, input logic [1:0] stg);
    phase_t res;
    res = PH_PAYLOAD;
    if (stg <= STG_HCRC && (flags & FL_HCRC[4:0]) != 5'd0) res = PH_HCRC;
    if (stg <= STG_COMMENT && (flags & FL_COMMENT[4:0]) != 5'd0) res = PH_COMMENT;
    if (stg <= STG_NAME && (flags & FL_NAME[4:0]) != 5'd0) res = PH_NAME;
    if (stg == STG_EXTRA && (flags & FL_EXTRA[4:0]) != 5'd0) res = PH_EXTRA_LO;
    return res;
  endfunction

endpackage

/* design/gzip_header_parser_unit.sv */
// An accepted input item's result item is registered and shown in the cycle after.
// Throughput: one byte per clock; a new item is taken whenever the result
// register is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): back to the fixed header, flags and counts
// cleared, error cleared, result register empty.
// ----------------------------------------------------------------------------
// gzip_header_parser_unit
// Walks a gzip member header one byte per item and tags each byte by kind.
// ----------------------------------------------------------------------------
`include "gzip_header_parser_unit_assert.svh"

module gzip_header_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_byte_kind,
  output logic [7:0] out_byte,
  output logic       out_header_done,
  output logic       out_header_error
);

  gzhp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       fix_cnt_r, fix_cnt_nxt;
  gzhp_pkg::flags_t flags_r, flags_nxt;
  logic [7:0]       ext_lo_r, ext_lo_nxt;
  logic [15:0]      ext_rem_r, ext_rem_nxt;
  logic             crc_cnt_r, crc_cnt_nxt;
  logic             err_r, err_nxt;
  gzhp_pkg::kind_t  kind;

  logic             out_valid_r;
  gzhp_pkg::kind_t  kind_r;
  logic [7:0]       byte_r;
  logic             done_r;
  logic             in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    phase_nxt   = phase_r;
    fix_cnt_nxt = fix_cnt_r;
    flags_nxt   = flags_r;
    ext_lo_nxt  = ext_lo_r;
    ext_rem_nxt = ext_rem_r;
    crc_cnt_nxt = crc_cnt_r;
    err_nxt     = err_r;
    kind        = gzhp_pkg::KIND_HEADER;
    if (!err_r) begin
      case (phase_r)
        gzhp_pkg::PH_FIXED: begin
          if (fix_cnt_r == gzhp_pkg::FIX_METHOD && in_byte != gzhp_pkg::METHOD_DEFLATE) begin
            err_nxt = 1'b1;
          end else if (fix_cnt_r == gzhp_pkg::FIX_FLAGS) begin
            if ((in_byte & gzhp_pkg::FL_RESERVED) != 8'd0) err_nxt = 1'b1;
            else flags_nxt = in_byte[4:0];
          end
          if (!err_nxt) begin
            if (fix_cnt_r >= gzhp_pkg::FIX_LAST)
              phase_nxt = gzhp_pkg::next_phase(flags_nxt, gzhp_pkg::STG_EXTRA);
            else
              fix_cnt_nxt = fix_cnt_r + 4'd1;
          end
        end
        gzhp_pkg::PH_EXTRA_LO: begin
          ext_lo_nxt = in_byte;
          phase_nxt  = gzhp_pkg::PH_EXTRA_HI;
        end
        gzhp_pkg::PH_EXTRA_HI: begin
          ext_rem_nxt = {in_byte, ext_lo_r};
          if (ext_rem_nxt == 16'd0)
            phase_nxt = gzhp_pkg::next_phase(flags_r, gzhp_pkg::STG_NAME);
          else
            phase_nxt = gzhp_pkg::PH_EXTRA;
        end
        gzhp_pkg::PH_EXTRA: begin
          ext_rem_nxt = ext_rem_r - 16'd1;
          if (ext_rem_nxt == 16'd0)
            phase_nxt = gzhp_pkg::next_phase(flags_r, gzhp_pkg::STG_NAME);
        end
        gzhp_pkg::PH_NAME: begin
          if (in_byte != 8'd0) kind = gzhp_pkg::KIND_NAME;
          else phase_nxt = gzhp_pkg::next_phase(flags_r, gzhp_pkg::STG_COMMENT);
        end
        gzhp_pkg::PH_COMMENT: begin
          if (in_byte != 8'd0) kind = gzhp_pkg::KIND_COMMENT;
          else phase_nxt = gzhp_pkg::next_phase(flags_r, gzhp_pkg::STG_HCRC);
        end
        gzhp_pkg::PH_HCRC: begin
          if (crc_cnt_r) begin
            crc_cnt_nxt = 1'b0;
            phase_nxt   = gzhp_pkg::PH_PAYLOAD;
          end else begin
            crc_cnt_nxt = 1'b1;
          end
        end
        default: begin
          kind = gzhp_pkg::KIND_PAYLOAD;
        end
      endcase
    end
    if (err_nxt) kind = gzhp_pkg::KIND_REJECT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= gzhp_pkg::PH_FIXED;
      fix_cnt_r   <= 4'd0;
      flags_r     <= 5'd0;
      ext_lo_r    <= 8'd0;
      ext_rem_r   <= 16'd0;
      crc_cnt_r   <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r   <= phase_nxt;
        fix_cnt_r <= fix_cnt_nxt;
        flags_r   <= flags_nxt;
        ext_lo_r  <= ext_lo_nxt;
        ext_rem_r <= ext_rem_nxt;
        crc_cnt_r <= crc_cnt_nxt;
        err_r     <= err_nxt;
      end
      if (in_fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // result register, every kind of item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= kind;
      byte_r <= in_byte;
      done_r <= !err_nxt && phase_nxt == gzhp_pkg::PH_PAYLOAD;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_kind    = kind_r;
  assign out_byte         = byte_r;
  assign out_header_done  = done_r;
  assign out_header_error = err_r;

  `GZHP_ASSERT_IMP(a_err_kind, out_valid && out_header_error, out_byte_kind == gzhp_pkg::KIND_REJECT)
  `GZHP_ASSERT_NXT(a_err_sticky, err_r, err_r)
  `GZHP_ASSERT_NXT(a_payload_pass, in_fire && !err_r && phase_r == gzhp_pkg::PH_PAYLOAD, out_valid && out_byte_kind == gzhp_pkg::KIND_PAYLOAD && out_header_done)

endmodule
